// ===== hw/rtl/sdsa_pkg.sv =====
`timescale 1ns / 1ps

package sdsa_pkg;

    localparam int OFF_X = 24;
    localparam int OFF_Y = 50;
    localparam int SPR_W = 24;
    localparam int SPR_H = 21;

    localparam int IN_DATA_W  = 88;
    localparam int OUT_DATA_W = 40;

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_CLEAR  = 2'd1,
        OP_COMMIT = 2'd2,
        OP_NONE   = 2'd3
    } opcode_t;

    typedef enum logic [2:0] {
        REG_SCREEN_WIDTH    = 3'd0,
        REG_VIEWPORT_BOTTOM = 3'd1,
        REG_NO_BITMAP_CODE  = 3'd2,
        REG_MSG_SHOWN       = 3'd3,
        REG_MSG_LEFT        = 3'd4,
        REG_MSG_RIGHT       = 3'd5,
        REG_IDLE_POINTER    = 3'd6,
        REG_IDLE_COLOR      = 3'd7
    } reg_index_t;

    typedef enum logic {
        ST_IDLE,
        ST_COMMIT
    } back_state_t;

    typedef struct packed {
        logic [8:0] screen_width;
        logic [7:0] viewport_bottom;
        logic [7:0] no_bitmap_code;
        logic       msg_shown;
        logic [8:0] msg_left;
        logic [8:0] msg_right;
        logic [7:0] idle_pointer;
        logic [3:0] idle_color;
    } cfg_t;

    typedef struct packed {
        opcode_t            op;
        logic               pass;
        logic signed [15:0] depth;
        logic [8:0]         hx;
        logic [7:0]         hy;
        logic [7:0]         bitmap;
        logic [7:0]         bitmap_lower;
        logic [3:0]         color;
        logic               expand;
    } item_t;

    typedef struct packed {
        logic signed [15:0] depth;
        logic [8:0]         hx;
        logic [7:0]         hy;
        logic [7:0]         bitmap;
        logic [7:0]         bitmap_lower;
        logic [3:0]         color;
        logic               expand;
    } entry_t;

    typedef struct packed {
        logic       slot_expand;
        logic [3:0] slot_color;
        logic [7:0] slot_pointer;
        logic [7:0] slot_y;
        logic [8:0] slot_x;
        logic       slot_enable;
        logic [2:0] slot;
        logic       accepted;
    } result_t;

endpackage

// ===== hw/rtl/sdsa_front.sv =====
`timescale 1ns / 1ps

module sdsa_front #(
    parameter int MSG_HEIGHT = 8
) (
    input  sdsa_pkg::cfg_t                      cfg,
    input  logic [1:0]                          opcode,
    input  logic [sdsa_pkg::IN_DATA_W-1:0]      data,
    output sdsa_pkg::item_t                     item
);
    import sdsa_pkg::*;

    logic signed [15:0] depth, pos_x, pos_y;
    logic signed [7:0]  pivot_x, pivot_y;
    logic [7:0]         bitmap, bitmap_lower;
    logic [3:0]         obj_color;
    logic               expand_x, align_dither, dbl;
    logic signed [19:0] px_e, x0, y0, xd, yd, wv, hv, sw, vb, ml, mr, mh;
    logic               cull, hide;

    always_comb
    begin
        depth        = data[15:0];
        pos_x        = data[31:16];
        pos_y        = data[47:32];
        pivot_x      = data[55:48];
        pivot_y      = data[63:56];
        bitmap       = data[71:64];
        bitmap_lower = data[79:72];
        obj_color    = data[83:80];
        expand_x     = data[84];
        align_dither = data[85];
        dbl          = bitmap_lower != cfg.no_bitmap_code;

        px_e = expand_x ? {{11{pivot_x[7]}}, pivot_x, 1'b0} : {{12{pivot_x[7]}}, pivot_x};
        x0   = {{4{pos_x[15]}}, pos_x} - px_e;
        y0   = {{4{pos_y[15]}}, pos_y} - {{12{pivot_y[7]}}, pivot_y};
        xd   = align_dither ? {x0[19:1], 1'b0} : x0;
        yd   = align_dither ? {y0[19:1], xd[1]} : y0;
        wv   = expand_x ? 20'(2 * SPR_W) : 20'(SPR_W);
        hv   = dbl ? 20'(2 * SPR_H) : 20'(SPR_H);
        sw   = {11'b0, cfg.screen_width};
        vb   = {12'b0, cfg.viewport_bottom};
        ml   = {11'b0, cfg.msg_left};
        mr   = {11'b0, cfg.msg_right};
        mh   = 20'(MSG_HEIGHT);

        cull = (xd >= sw) || ((xd + wv) <= 20'sd0)
            || (yd >= vb) || ((yd + hv) <= 20'sd0)
            || (xd < -20'(OFF_X));
        hide = cfg.msg_shown && (yd < mh) && ((yd + hv) > 20'sd0)
            && (xd < mr) && ((xd + wv) > ml);

        item.op           = opcode_t'(opcode);
        item.pass         = !cull && !hide;
        item.depth        = depth;
        item.hx           = 9'(xd + 20'(OFF_X));
        item.hy           = 8'(yd + 20'(OFF_Y));
        item.bitmap       = bitmap;
        item.bitmap_lower = bitmap_lower;
        item.color        = obj_color;
        item.expand       = expand_x;
    end

endmodule

// ===== hw/rtl/sdsa_queue.sv =====
`timescale 1ns / 1ps

module sdsa_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  sdsa_pkg::item_t push_item,
    output logic            not_full,
    input  logic            pop,
    output logic            not_empty,
    output sdsa_pkg::item_t head
);
    import sdsa_pkg::*;

    item_t      mem_reg [2];
    logic       wptr_reg, wptr_next, rptr_reg, rptr_next;
    logic [1:0] cnt_reg, cnt_next;

    assign not_full  = cnt_reg != 2'd2;
    assign not_empty = cnt_reg != 2'd0;
    assign head      = mem_reg[rptr_reg];

    always_comb
    begin
        wptr_next = wptr_reg ^ push;
        rptr_next = rptr_reg ^ pop;
        cnt_next  = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wptr_reg] <= push_item;
        end
    end

endmodule

// ===== hw/rtl/sdsa_back.sv =====
`timescale 1ns / 1ps

module sdsa_back #(
    parameter int SLOTS = 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  sdsa_pkg::cfg_t                    cfg,
    input  logic                              q_valid,
    input  sdsa_pkg::item_t                   q_item,
    output logic                              q_pop,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [sdsa_pkg::OUT_DATA_W-1:0]   m_tdata,
    output logic                              m_tlast
);
    import sdsa_pkg::*;

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);

    entry_t        ent_reg [SLOTS];
    entry_t        ent_next [SLOTS];
    logic [CW-1:0] count_reg, count_next;
    back_state_t   state_reg, state_next;
    logic [IW-1:0] sidx_reg, sidx_next;
    logic [CW-1:0] eidx_reg, eidx_next;
    logic          half_reg, half_next, stop_reg, stop_next;
    logic          ov_reg, ov_next, olast_reg, olast_next;
    result_t       ores_reg, ores_next;

    logic          load, full, reject, live, fits, dbl;
    logic [SLOTS-1:0] le;
    logic [CW-1:0] pos;
    entry_t        cur, nent;

    assign load     = !ov_reg || m_tready;
    assign m_tvalid = ov_reg;
    assign m_tlast  = olast_reg;
    assign m_tdata  = {(OUT_DATA_W - $bits(result_t))'(0), ores_reg};

    always_comb
    begin
        for (int i = 0; i < SLOTS; i++)
        begin
            le[i] = (CW'(i) < count_reg) && (ent_reg[i].depth <= q_item.depth);
        end
        pos    = CW'($countones(le));
        full   = count_reg == CW'(SLOTS);
        reject = !q_item.pass || (full && q_item.depth >= ent_reg[SLOTS-1].depth);

        nent.depth        = q_item.depth;
        nent.hx           = q_item.hx;
        nent.hy           = q_item.hy;
        nent.bitmap       = q_item.bitmap;
        nent.bitmap_lower = q_item.bitmap_lower;
        nent.color        = q_item.color;
        nent.expand       = q_item.expand;

        cur  = ent_reg[eidx_reg[IW-1:0]];
        dbl  = cur.bitmap_lower != cfg.no_bitmap_code;
        live = !stop_reg && (eidx_reg < count_reg);
        fits = !dbl || half_reg || (sidx_reg != IW'(SLOTS - 1));

        for (int i = 0; i < SLOTS; i++)
        begin
            ent_next[i] = ent_reg[i];
        end
        count_next = count_reg;
        state_next = state_reg;
        sidx_next  = sidx_reg;
        eidx_next  = eidx_reg;
        half_next  = half_reg;
        stop_next  = stop_reg;
        ov_next    = ov_reg && !m_tready;
        olast_next = olast_reg;
        ores_next  = ores_reg;
        q_pop      = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid && load)
                begin
                    q_pop     = 1'b1;
                    ores_next = '0;
                    unique case (q_item.op)
                        OP_ADD:
                        begin
                            ov_next            = 1'b1;
                            olast_next         = 1'b1;
                            ores_next.accepted = !reject;
                            if (!reject)
                            begin
                                for (int i = 0; i < SLOTS; i++)
                                begin
                                    if (CW'(i) == pos)
                                    begin
                                        ent_next[i] = nent;
                                    end
                                    else if (CW'(i) > pos && i > 0)
                                    begin
                                        ent_next[i] = ent_reg[(i > 0) ? i - 1 : 0];
                                    end
                                end
                                if (!full)
                                begin
                                    count_next = count_reg + CW'(1);
                                end
                            end
                        end
                        OP_CLEAR:
                        begin
                            ov_next    = 1'b1;
                            olast_next = 1'b1;
                            count_next = '0;
                        end
                        OP_COMMIT:
                        begin
                            state_next = ST_COMMIT;
                            sidx_next  = '0;
                            eidx_next  = '0;
                            half_next  = 1'b0;
                            stop_next  = 1'b0;
                        end
                        default:
                        begin
                            ov_next    = 1'b1;
                            olast_next = 1'b1;
                        end
                    endcase
                end
            end
            ST_COMMIT:
            begin
                if (load)
                begin
                    ov_next    = 1'b1;
                    olast_next = sidx_reg == IW'(SLOTS - 1);
                    ores_next  = '0;
                    ores_next.slot = 3'(sidx_reg);
                    if (live && fits)
                    begin
                        ores_next.slot_enable  = 1'b1;
                        ores_next.slot_x       = cur.hx;
                        ores_next.slot_y       = half_reg ? cur.hy + 8'(SPR_H) : cur.hy;
                        ores_next.slot_pointer = half_reg ? cur.bitmap_lower : cur.bitmap;
                        ores_next.slot_color   = cur.color;
                        ores_next.slot_expand  = cur.expand;
                        if (dbl && !half_reg)
                        begin
                            half_next = 1'b1;
                        end
                        else
                        begin
                            half_next = 1'b0;
                            eidx_next = eidx_reg + CW'(1);
                        end
                    end
                    else
                    begin
                        stop_next              = 1'b1;
                        ores_next.slot_pointer = cfg.idle_pointer;
                        ores_next.slot_color   = cfg.idle_color;
                    end
                    sidx_next = sidx_reg + IW'(1);
                    if (sidx_reg == IW'(SLOTS - 1))
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            ov_reg    <= 1'b0;
            sidx_reg  <= '0;
            eidx_reg  <= '0;
            half_reg  <= 1'b0;
            stop_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            ov_reg    <= ov_next;
            sidx_reg  <= sidx_next;
            eidx_reg  <= eidx_next;
            half_reg  <= half_next;
            stop_reg  <= stop_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < SLOTS; i++)
        begin
            ent_reg[i] <= ent_next[i];
        end
        olast_reg <= olast_next;
        ores_reg  <= ores_next;
    end

endmodule

// ===== hw/rtl/depth_sorted_sprite_slot_allocator.sv =====
`timescale 1ns / 1ps

// Depth-sorted sprite slot allocator.
// Input stream (s_*): one command per transfer, opcode in s_tuser: add an
// object, clear the list, or commit the frame. An add is culled against the
// screen, the viewport and the message box, then insertion-sorted by depth.
// Output stream (m_*): an add or clear returns one record (accepted flag);
// a commit returns SLOTS slot records, near to far, m_tlast on the final one.
// Configuration goes through the APB port, registers at 4-byte steps; write
// only while the block is idle.
// An add or clear record passes through the queue and then the output
// register; a commit passes through the queue, then the commit state, before
// its records reach the output register. The whole insertion shift of an add
// happens at once in the back end. A commit gives one slot record per cycle
// from the commit sequencer while the receiver is ready.
// A two-entry queue parts the culling front end from the list back end, so
// input keeps flowing while the output stalls until the queue fills.
// Reset empties the list and the queue and loads register defaults.
// A stalled receiver holds the output record and freezes the back end.
module depth_sorted_sprite_slot_allocator #(
    parameter int SLOTS      = 8,
    parameter int MSG_HEIGHT = 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // depth, pos_x, pos_y, pivot_x, pivot_y, bitmap, bitmap_lower, obj_color,
    // expand_x, align_dither
    input  logic [sdsa_pkg::IN_DATA_W-1:0]    s_tdata,
    // opcode
    input  logic [1:0]                        s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // accepted, slot, slot_enable, slot_x, slot_y, slot_pointer, slot_color,
    // slot_expand
    output logic [sdsa_pkg::OUT_DATA_W-1:0]   m_tdata,
    output logic                              m_tlast,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [4:0]                        paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);
    import sdsa_pkg::*;

    cfg_t       cfg_reg, cfg_next;
    item_t      f_item, q_head;
    logic       q_not_full, q_not_empty, q_pop, wr_en;
    reg_index_t ridx;

    assign pready = 1'b1;
    assign ridx   = reg_index_t'(paddr[4:2]);
    assign wr_en  = psel && penable && pwrite && pready;

    always_comb
    begin
        cfg_next = cfg_reg;
        prdata   = '0;
        unique case (ridx)
            REG_SCREEN_WIDTH:    prdata = 32'(cfg_reg.screen_width);
            REG_VIEWPORT_BOTTOM: prdata = 32'(cfg_reg.viewport_bottom);
            REG_NO_BITMAP_CODE:  prdata = 32'(cfg_reg.no_bitmap_code);
            REG_MSG_SHOWN:       prdata = 32'(cfg_reg.msg_shown);
            REG_MSG_LEFT:        prdata = 32'(cfg_reg.msg_left);
            REG_MSG_RIGHT:       prdata = 32'(cfg_reg.msg_right);
            REG_IDLE_POINTER:    prdata = 32'(cfg_reg.idle_pointer);
            REG_IDLE_COLOR:      prdata = 32'(cfg_reg.idle_color);
            default:             prdata = '0;
        endcase
        if (wr_en)
        begin
            unique case (ridx)
                REG_SCREEN_WIDTH:    cfg_next.screen_width    = pwdata[8:0];
                REG_VIEWPORT_BOTTOM: cfg_next.viewport_bottom = pwdata[7:0];
                REG_NO_BITMAP_CODE:  cfg_next.no_bitmap_code  = pwdata[7:0];
                REG_MSG_SHOWN:       cfg_next.msg_shown       = pwdata[0];
                REG_MSG_LEFT:        cfg_next.msg_left        = pwdata[8:0];
                REG_MSG_RIGHT:       cfg_next.msg_right       = pwdata[8:0];
                REG_IDLE_POINTER:    cfg_next.idle_pointer    = pwdata[7:0];
                REG_IDLE_COLOR:      cfg_next.idle_color      = pwdata[3:0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.screen_width    <= 9'd320;
            cfg_reg.viewport_bottom <= 8'd112;
            cfg_reg.no_bitmap_code  <= 8'd255;
            cfg_reg.msg_shown       <= 1'b0;
            cfg_reg.msg_left        <= 9'd0;
            cfg_reg.msg_right       <= 9'd0;
            cfg_reg.idle_pointer    <= 8'd0;
            cfg_reg.idle_color      <= 4'd1;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign s_tready = q_not_full;

    sdsa_front #(
        .MSG_HEIGHT(MSG_HEIGHT)
    ) u_front (
        .cfg   (cfg_reg),
        .opcode(s_tuser),
        .data  (s_tdata),
        .item  (f_item)
    );

    sdsa_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (s_tvalid && q_not_full),
        .push_item(f_item),
        .not_full (q_not_full),
        .pop      (q_pop),
        .not_empty(q_not_empty),
        .head     (q_head)
    );

    sdsa_back #(
        .SLOTS(SLOTS)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .q_valid (q_not_empty),
        .q_item  (q_head),
        .q_pop   (q_pop),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast)
    );

endmodule

// ===== hw/rtl/sdsa_checker.sv =====
`timescale 1ns / 1ps

module sdsa_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [sdsa_pkg::OUT_DATA_W-1:0] m_tdata,
    input logic                            m_tlast
);
    import sdsa_pkg::*;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output changed during stall");

    a_acc_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[0] |-> m_tlast)
        else $error("accepted flag on a non-final record");

    a_en_noacc: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[4] |-> !m_tdata[0])
        else $error("slot record carries accepted flag");

    a_slot_order: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && !m_tlast |=> m_tdata[3:1] != 3'd0 || !m_tvalid)
        else $error("commit record sequence restarted early");

endmodule

bind depth_sorted_sprite_slot_allocator sdsa_checker u_sdsa_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast)
);
